@@ sv/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg - shared types and constants of the sliding-window maximum
// Default sizes, the register layout, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

	// default sizes
	localparam int WINDOW_MAX_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// window_size register
	localparam int            WS_W     = 5;
	localparam logic [WS_W-1:0] WS_RESET = 5'd1;

	// controller states, one-hot
	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_PEND  = 2'b10
	} swm_state_t;

	// controller to datapath
	typedef struct packed {
		logic shift;   // take the input word into the sample line
		logic load;    // copy the window front into the output register
	} swm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;    // the word on the input would complete a full window
	} swm_sts_t;

endpackage

@@ sv/swm_ctrl.sv @@
// ----------------------------------------------------------------------------
// swm_ctrl - handshake controller of the sliding-window maximum
// Tracks whether the sample line holds a result not yet moved to the
// output register, and drives both handshakes.
// ----------------------------------------------------------------------------
module swm_ctrl
	import swm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  swm_sts_t sts,
	output swm_cmd_t cmd
);

	swm_state_t st_q, st_d;
	logic       out_valid_q;
	logic       move;
	logic       accept;

	// move a pending result when the output register is free or being taken
	assign move     = (st_q == ST_PEND) && (!out_valid_q || !out_stall);
	assign in_stall = (st_q == ST_PEND) && !move;
	assign accept   = in_valid && !in_stall;

	assign cmd.shift = accept;
	assign cmd.load  = move;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_EMPTY: begin
				if (accept && sts.emit) st_d = ST_PEND;
			end
			ST_PEND: begin
				if (accept && sts.emit) st_d = ST_PEND;
				else if (move)          st_d = ST_EMPTY;
			end
			default: st_d = ST_EMPTY;
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// a stall on the input only while a result waits in the line
	a_stall_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (st_q == ST_PEND))
		else $error("input stalled with no pending result");

	// a load always presents a word next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	// an emitting word always leaves a pending result
	a_emit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && sts.emit) |=> (st_q == ST_PEND))
		else $error("emitting word left no pending result");

endmodule

@@ sv/swm_dp.sv @@
// ----------------------------------------------------------------------------
// swm_dp - datapath of the sliding-window maximum
// Sample line indexed by age with one candidate flag per tap. A tap stays
// a candidate while it is inside the window and no newer sample is larger;
// the oldest candidate is the window maximum.
// ----------------------------------------------------------------------------
module swm_dp
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [WS_W-1:0]                cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           first,
	output logic signed [SAMPLE_WIDTH-1:0] maximum,
	input  swm_cmd_t                       cmd,
	output swm_sts_t                       sts
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

	logic [WS_W-1:0]                window_size_q;
	logic signed [SAMPLE_WIDTH-1:0] tap_q [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]          cand_q;
	logic [WINDOW_MAX-1:0]          cand_d;
	logic [WINDOW_MAX-1:0]          front_oh;
	logic [CNT_W-1:0]               seen_q;
	logic [CNT_W-1:0]               seen_d;
	logic [CMP_W-1:0]               ws_ext;
	logic [CMP_W-1:0]               w_eff;
	logic signed [SAMPLE_WIDTH-1:0] front_val;
	logic signed [SAMPLE_WIDTH-1:0] maximum_q;

	// clamp the window to 1..WINDOW_MAX
	always_comb begin
		ws_ext = CMP_W'(window_size_q);
		priority if (ws_ext == '0)
			w_eff = CMP_W'(1);
		else if (ws_ext > CMP_W'(WINDOW_MAX))
			w_eff = CMP_W'(WINDOW_MAX);
		else
			w_eff = ws_ext;
	end

	// sequence length, saturating
	always_comb begin
		if (first)
			seen_d = CNT_W'(1);
		else if (seen_q == CNT_W'(WINDOW_MAX))
			seen_d = seen_q;
		else
			seen_d = seen_q + CNT_W'(1);
	end

	assign sts.emit = (CMP_W'(seen_d) >= w_eff);

	// candidate flags after the new word: drop aged-out and smaller taps
	always_comb begin
		cand_d    = '0;
		cand_d[0] = 1'b1;
		for (int k = 1; k < WINDOW_MAX; k++) begin
			cand_d[k] = !first && cand_q[k-1] && (CMP_W'(k) < w_eff) &&
				(tap_q[k-1] >= sample);
		end
	end

	// oldest candidate is the window front
	always_comb begin
		front_val = '0;
		for (int k = 0; k < WINDOW_MAX; k++) begin
			front_oh[k] = cand_q[k] && ((cand_q >> (k + 1)) == '0);
			front_val   = front_val | ({SAMPLE_WIDTH{front_oh[k]}} & tap_q[k]);
		end
	end

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_size_q <= WS_RESET;
		else if (cfg_write)
			window_size_q <= cfg_data;
	end

	// advance candidate flags and sequence count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			seen_q <= '0;
		end else if (cmd.shift) begin
			cand_q <= cand_d;
			seen_q <= seen_d;
		end
	end

	// advance the sample line
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			tap_q[0] <= sample;
			for (int k = 1; k < WINDOW_MAX; k++)
				tap_q[k] <= tap_q[k-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load)
			maximum_q <= front_val;
	end

	assign maximum = maximum_q;

	// the newest word is always a candidate
	a_new_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |=> cand_q[0])
		else $error("new word not kept as candidate");

	// a new sequence keeps only its own first word
	a_first_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && first) |=> (cand_q == WINDOW_MAX'(1)))
		else $error("window not cleared on first word");

	// a load always finds a front
	a_load_front: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $onehot(front_oh))
		else $error("no single window front on load");

endmodule

@@ sv/sliding_window_maximum_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_maximum_core - maximum over the last window_size samples
// A result waits as pending, then is loaded into the output register.
// Throughput: one word per cycle while the output is not stalled; the
// candidate update of the whole sample line completes in the accept cycle.
// Reset: clears the candidate flags, the sequence count and the output
// valid, and sets window_size to 1. Sample taps hold no reset value.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [WS_W-1:0]                cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           first,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] maximum
);

	swm_cmd_t cmd;
	swm_sts_t sts;

	// handshake control
	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// sample line, candidates and output register
	swm_dp #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.first     (first),
		.maximum   (maximum),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
